### sv/pwm_pulse_width_capture_unit_assert.svh
// Assertion macros for the pulse width capture unit.
`ifndef PWM_PULSE_WIDTH_CAPTURE_UNIT_ASSERT_SVH
`define PWM_PULSE_WIDTH_CAPTURE_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define PWC_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pwc check failed");

// Check cons in the cycle after ante.
`define PWC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pwc check failed");

`endif

### sv/pwc_pkg.sv
// Shared types and constants for the pulse width capture unit.
package pwc_pkg;

	localparam int ENABLE_BITS = 8;
	localparam int CHAN_W      = 3;
	localparam int TIME_BITS   = 48;
	localparam int WIDTH_W     = 16;
	localparam int AGE_W       = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;

	localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST = 16'd200;
	localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST = 16'd5000;
	localparam logic [AGE_W-1:0]   MAX_AGE_RST   = 24'd60000;

	typedef enum logic [1:0] {
		CMD_RISE = 2'd0,
		CMD_FALL = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_VALID    = 2'd0,
		STATUS_DISABLED = 2'd1,
		STATUS_NO_PULSE = 2'd2,
		STATUS_STALE    = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_ENABLE = 2'd0,
		REG_MIN_WIDTH      = 2'd1,
		REG_MAX_WIDTH      = 2'd2,
		REG_MAX_AGE        = 2'd3
	} reg_idx_t;

endpackage

### sv/pwc_if.sv
// Channel interfaces: capture events, read reports and configuration writes.
interface pwc_in_if import pwc_pkg::*;;
	logic                 valid;
	logic                 ready;
	cmd_t                 command;
	logic [CHAN_W-1:0]    channel;
	logic [TIME_BITS-1:0] time_us;

	modport source (output valid, output command, output channel, output time_us, input ready);
	modport sink (input valid, input command, input channel, input time_us, output ready);
endinterface

interface pwc_out_if import pwc_pkg::*;;
	logic               valid;
	logic               ready;
	status_t            status;
	logic [WIDTH_W-1:0] pulse_len;

	modport source (output valid, output status, output pulse_len, input ready);
	modport sink (input valid, input status, input pulse_len, output ready);
endinterface

interface pwc_cfg_if import pwc_pkg::*;;
	logic                  valid;
	logic                  ready;
	reg_idx_t              index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### sv/pwm_pulse_width_capture_unit.sv
// Top level: multi-channel PWM pulse width capture with freshness timeout.
//
//   port     dir   carries
//   cfg      in    register index, write data
//   capture  in    command, channel, time_us
//   report   out   status, pulse_len (one per read)
//
// One item per cycle while no read waits; an item is held in the input stage
// register, and a read result is then registered in the report register.
// Per-channel state is read and updated in the same cycle, so items follow
// back to back with no hazard. Reset clears channel flags and loads defaults.
// A read waits in the input stage only while the report register is full and
// not taken; edges never wait there, but a waiting read holds off new items.
`include "pwm_pulse_width_capture_unit_assert.svh"

module pwm_pulse_width_capture_unit import pwc_pkg::*; #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	pwc_cfg_if.sink    cfg,
	pwc_in_if.sink     capture,
	pwc_out_if.source  report
);

	localparam int NCH = (NUM_CHANNELS < ENABLE_BITS) ? NUM_CHANNELS : ENABLE_BITS;

	logic                 s1_valid_q;
	cmd_t                 cmd_s1;
	logic [CHAN_W-1:0]    chan_s1;
	logic [TIME_BITS-1:0] time_s1;

	logic [ENABLE_BITS-1:0] enable_q;
	logic [WIDTH_W-1:0]     min_width_q;
	logic [WIDTH_W-1:0]     max_width_q;
	logic [AGE_W-1:0]       max_age_q;

	logic [NCH-1:0]       rise_seen_q;
	logic [NCH-1:0]       pulse_seen_q;
	logic [TIME_BITS-1:0] rise_time_q [NCH];
	logic [WIDTH_W-1:0]   pulse_width_q [NCH];
	logic [TIME_BITS-1:0] pulse_end_q [NCH];

	logic               out_valid_q;
	status_t            status_q;
	logic [WIDTH_W-1:0] width_q;

	logic [NCH-1:0]         hit;
	logic                   sel_rise_seen;
	logic                   sel_pulse_seen;
	logic [TIME_BITS-1:0]   sel_rise_time;
	logic [WIDTH_W-1:0]     sel_width;
	logic [TIME_BITS-1:0]   sel_end;
	logic [TIME_BITS-1:0]   span;
	logic [TIME_BITS-1:0]   age;
	logic                   plausible;
	logic                   fresh;
	logic                   out_free;
	logic                   is_read;
	logic                   stall;
	logic                   advance;
	logic                   do_rise;
	logic                   do_fall;
	logic                   keep;
	logic                   cfg_wr;
	logic                   enable_wr;
	logic [ENABLE_BITS-1:0] rising;
	status_t                status_d;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign enable_wr = cfg_wr && (cfg.index == REG_CHANNEL_ENABLE);
	assign rising    = cfg.data[ENABLE_BITS-1:0] & ~enable_q;

	always_comb begin
		sel_rise_seen  = 1'b0;
		sel_pulse_seen = 1'b0;
		sel_rise_time  = '0;
		sel_width      = '0;
		sel_end        = '0;
		for (int c = 0; c < NCH; c++) begin
			hit[c] = (chan_s1 == CHAN_W'(c)) && enable_q[c];
			if (hit[c]) begin
				sel_rise_seen  = rise_seen_q[c];
				sel_pulse_seen = pulse_seen_q[c];
				sel_rise_time  = rise_time_q[c];
				sel_width      = pulse_width_q[c];
				sel_end        = pulse_end_q[c];
			end
		end
	end

	assign span      = time_s1 - sel_rise_time;
	assign age       = time_s1 - sel_end;
	assign plausible = (span >= {{(TIME_BITS-WIDTH_W){1'b0}}, min_width_q}) &&
	                   (span <= {{(TIME_BITS-WIDTH_W){1'b0}}, max_width_q});
	assign fresh     = (time_s1 >= sel_end) &&
	                   (age <= {{(TIME_BITS-AGE_W){1'b0}}, max_age_q});

	assign out_free      = !out_valid_q || report.ready;
	assign is_read       = s1_valid_q && (cmd_s1 == CMD_READ);
	assign stall         = is_read && !out_free;
	assign advance       = s1_valid_q && !stall;
	assign capture.ready = !stall;

	assign do_rise = advance && (cmd_s1 == CMD_RISE);
	assign do_fall = advance && (cmd_s1 == CMD_FALL) && sel_rise_seen;
	assign keep    = do_fall && plausible;

	always_comb begin
		if (hit == '0) begin
			status_d = STATUS_DISABLED;
		end else if (!sel_pulse_seen) begin
			status_d = STATUS_NO_PULSE;
		end else if (!fresh) begin
			status_d = STATUS_STALE;
		end else begin
			status_d = STATUS_VALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= '0;
			min_width_q <= MIN_WIDTH_RST;
			max_width_q <= MAX_WIDTH_RST;
			max_age_q   <= MAX_AGE_RST;
		end else if (cfg_wr) begin
			case (cfg.index)
				REG_CHANNEL_ENABLE: enable_q    <= cfg.data[ENABLE_BITS-1:0];
				REG_MIN_WIDTH:      min_width_q <= cfg.data[WIDTH_W-1:0];
				REG_MAX_WIDTH:      max_width_q <= cfg.data[WIDTH_W-1:0];
				REG_MAX_AGE:        max_age_q   <= cfg.data[AGE_W-1:0];
				default:            enable_q    <= enable_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (capture.ready) begin
			s1_valid_q <= capture.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (capture.valid && capture.ready) begin
			cmd_s1  <= capture.command;
			chan_s1 <= capture.channel;
			time_s1 <= capture.time_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_seen_q  <= '0;
			pulse_seen_q <= '0;
		end else begin
			for (int c = 0; c < NCH; c++) begin
				if (enable_wr && rising[c]) begin
					rise_seen_q[c]  <= 1'b0;
					pulse_seen_q[c] <= 1'b0;
				end else if (hit[c]) begin
					if (do_rise) begin
						rise_seen_q[c] <= 1'b1;
					end
					if (do_fall) begin
						rise_seen_q[c] <= 1'b0;
					end
					if (keep) begin
						pulse_seen_q[c] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NCH; c++) begin
			if (hit[c] && do_rise) begin
				rise_time_q[c] <= time_s1;
			end
			if (hit[c] && keep) begin
				pulse_width_q[c] <= span[WIDTH_W-1:0];
				pulse_end_q[c]   <= time_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= is_read;
		end
	end

	always_ff @(posedge clk) begin
		if (is_read && out_free) begin
			status_q <= status_d;
			width_q  <= (status_d == STATUS_VALID) ? sel_width : '0;
		end
	end

	assign report.valid     = out_valid_q;
	assign report.status    = status_q;
	assign report.pulse_len = width_q;

	`PWC_ASSERT_SAME(a_ready_only_on_full_report, !capture.ready, out_valid_q && !report.ready)
	`PWC_ASSERT_SAME(a_report_from_read, $rose(out_valid_q), $past(is_read))
	`PWC_ASSERT_SAME(a_width_zero_unless_valid, out_valid_q && status_q != STATUS_VALID, width_q == '0)
	`PWC_ASSERT_NEXT(a_enable_clears_flags, enable_wr, ((rise_seen_q | pulse_seen_q) & $past(rising[NCH-1:0])) == '0)

endmodule
